@@ rtl/hsvrgb_pkg.sv @@
// Package for the HSV to RGB converter: widths, hue constants, sector codes
// and the beat structs that travel between pipeline stages. No dependencies.
`default_nettype none

package hsvrgb_pkg;

    localparam int FRAC_BITS = 12;
    localparam int FIELD_W   = FRAC_BITS + 1;
    localparam logic [FIELD_W-1:0] ONE = FIELD_W'(1) << FRAC_BITS;

    localparam int HUE_W = 16;
    localparam int HR_W  = 15;   // reduced hue, below 23040
    localparam int T_W   = 13;   // hue within a sector pair, below 7680
    localparam int K_W   = 12;   // secondary weight, 0..3840

    localparam logic [HUE_W-1:0] HUE_FULL   = 16'd23040;
    localparam logic [HUE_W-1:0] HUE_FULL2  = 16'd46080;
    localparam logic [HR_W-1:0]  HUE_SECTOR = 15'd3840;
    localparam logic [HR_W-1:0]  HUE_PAIR   = 15'd7680;
    localparam logic [HR_W-1:0]  HUE_PAIR2  = 15'd15360;

    // divide by 3840 = 256 * 15: shift, then multiply by ceil(2^19 / 15)
    localparam int PRE_SHIFT   = 8;
    localparam int Q_W         = 16;
    localparam int DIV15_SHIFT = 19;
    localparam logic [Q_W-1:0] DIV15_MUL = 16'd34953;

    localparam int PROD_W = FIELD_W + K_W;

    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } t_sector;

    typedef struct packed {
        t_sector              sector;
        logic [K_W-1:0]       k;
        logic [FIELD_W-1:0]   c;
        logic [FIELD_W-1:0]   v;
    } t_front_beat;

    typedef struct packed {
        t_sector              sector;
        logic [FIELD_W-1:0]   c;
        logic [FIELD_W-1:0]   x;
        logic [FIELD_W-1:0]   m;
    } t_scale_beat;

endpackage

`default_nettype wire

@@ rtl/hsvrgb_if.sv @@
// Valid/ready channel interfaces for HSV input beats and RGB result beats.
// Depends on hsvrgb_pkg for field widths.
`default_nettype none

interface hsvrgb_in_if
    import hsvrgb_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [HUE_W-1:0]   hue;
    logic [FIELD_W-1:0] saturation;
    logic [FIELD_W-1:0] brightness;

    modport source (output valid, hue, saturation, brightness, input ready);
    modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

interface hsvrgb_out_if
    import hsvrgb_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] red;
    logic [FIELD_W-1:0] green;
    logic [FIELD_W-1:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

`default_nettype wire

@@ rtl/hsvrgb_front.sv @@
// Front two stages: hue wrap and input clamp, then sector, secondary weight
// and chroma c = v*s. Depends on hsvrgb_pkg and hsvrgb_if.
`default_nettype none

module hsvrgb_front
    import hsvrgb_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    hsvrgb_in_if.sink         i_hsv,
    output logic              o_valid,
    input  wire logic         i_ready,
    output t_front_beat       o_beat
);

    logic               r_a_valid;
    logic [HR_W-1:0]    r_a_hr;
    logic [FIELD_W-1:0] r_a_s;
    logic [FIELD_W-1:0] r_a_v;
    logic               r_b_valid;
    t_front_beat        r_b_beat;

    logic               a_en, b_en;
    logic [HR_W-1:0]    n_a_hr;
    logic [FIELD_W-1:0] n_a_s, n_a_v;
    t_front_beat        n_b_beat;
    logic [HR_W-1:0]    t_full;
    logic [K_W-1:0]     mid_dev;
    logic [2*FIELD_W-1:0] vs;

    assign b_en        = !r_b_valid || i_ready;
    assign a_en        = !r_a_valid || b_en;
    assign i_hsv.ready = a_en;

    always_comb begin
        priority if (i_hsv.hue >= HUE_FULL2) begin
            n_a_hr = HR_W'(i_hsv.hue - HUE_FULL2);
        end else if (i_hsv.hue >= HUE_FULL) begin
            n_a_hr = HR_W'(i_hsv.hue - HUE_FULL);
        end else begin
            n_a_hr = HR_W'(i_hsv.hue);
        end
        n_a_s = (i_hsv.saturation > ONE) ? ONE : i_hsv.saturation;
        n_a_v = (i_hsv.brightness > ONE) ? ONE : i_hsv.brightness;
    end

    always_comb begin
        priority if (r_a_hr >= HR_W'(5 * 3840)) begin
            n_b_beat.sector = SEC_MAG_RED;
        end else if (r_a_hr >= HR_W'(4 * 3840)) begin
            n_b_beat.sector = SEC_BLU_MAG;
        end else if (r_a_hr >= HR_W'(3 * 3840)) begin
            n_b_beat.sector = SEC_CYN_BLU;
        end else if (r_a_hr >= HR_W'(2 * 3840)) begin
            n_b_beat.sector = SEC_GRN_CYN;
        end else if (r_a_hr >= HUE_SECTOR) begin
            n_b_beat.sector = SEC_YEL_GRN;
        end else begin
            n_b_beat.sector = SEC_RED_YEL;
        end

        priority if (r_a_hr >= HUE_PAIR2) begin
            t_full = r_a_hr - HUE_PAIR2;
        end else if (r_a_hr >= HUE_PAIR) begin
            t_full = r_a_hr - HUE_PAIR;
        end else begin
            t_full = r_a_hr;
        end

        // distance from the sector boundary in the middle of the pair
        if (t_full >= HUE_SECTOR) begin
            mid_dev = K_W'(t_full - HUE_SECTOR);
        end else begin
            mid_dev = K_W'(HUE_SECTOR - t_full);
        end
        n_b_beat.k = K_W'(HUE_SECTOR) - mid_dev;

        vs         = (2*FIELD_W)'(r_a_v) * (2*FIELD_W)'(r_a_s);
        n_b_beat.c = vs[FRAC_BITS +: FIELD_W];
        n_b_beat.v = r_a_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (a_en) begin
                r_a_valid <= i_hsv.valid;
            end
            if (b_en) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_en && i_hsv.valid) begin
            r_a_hr <= n_a_hr;
            r_a_s  <= n_a_s;
            r_a_v  <= n_a_v;
        end
        if (b_en && r_a_valid) begin
            r_b_beat <= n_b_beat;
        end
    end

    assign o_valid = r_b_valid;
    assign o_beat  = r_b_beat;

endmodule

`default_nettype wire

@@ rtl/hsvrgb_scale.sv @@
// Middle two stages: product c*k and m = v - c, then x = c*k / 3840 by a
// shift and a reciprocal multiply. Depends on hsvrgb_pkg.
`default_nettype none

module hsvrgb_scale
    import hsvrgb_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire t_front_beat  i_beat,
    output logic              o_valid,
    input  wire logic         i_ready,
    output t_scale_beat       o_beat
);

    logic               r_c_valid;
    logic [PROD_W-1:0]  r_c_prod;
    t_sector            r_c_sector;
    logic [FIELD_W-1:0] r_c_c;
    logic [FIELD_W-1:0] r_c_m;
    logic               r_d_valid;
    t_scale_beat        r_d_beat;

    logic               c_en, d_en;
    logic [PROD_W-1:0]  n_c_prod;
    logic [Q_W-1:0]     q;
    logic [2*Q_W-1:0]   qm;
    t_scale_beat        n_d_beat;

    assign d_en    = !r_d_valid || i_ready;
    assign c_en    = !r_c_valid || d_en;
    assign o_ready = c_en;

    assign n_c_prod = PROD_W'(i_beat.c) * PROD_W'(i_beat.k);

    always_comb begin
        q               = r_c_prod[PRE_SHIFT +: Q_W];
        qm              = (2*Q_W)'(q) * (2*Q_W)'(DIV15_MUL);
        n_d_beat.sector = r_c_sector;
        n_d_beat.c      = r_c_c;
        n_d_beat.x      = qm[DIV15_SHIFT +: FIELD_W];
        n_d_beat.m      = r_c_m;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            if (c_en) begin
                r_c_valid <= i_valid;
            end
            if (d_en) begin
                r_d_valid <= r_c_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_en && i_valid) begin
            r_c_prod   <= n_c_prod;
            r_c_sector <= i_beat.sector;
            r_c_c      <= i_beat.c;
            r_c_m      <= i_beat.v - i_beat.c;
        end
        if (d_en && r_c_valid) begin
            r_d_beat <= n_d_beat;
        end
    end

    assign o_valid = r_d_valid;
    assign o_beat  = r_d_beat;

endmodule

`default_nettype wire

@@ rtl/hsv_to_rgb_converter_top.sv @@
// HSV to RGB converter, five register stages, one beat per clock cycle.
// Each beat passes the front stages, the scale stages and then the output register.
// Throughput: one beat per cycle, set by the fully pipelined datapath; a
// stall on the output holds every stage without loss.
// Reset (synchronous, active low) clears all stage valid bits.
`default_nettype none

module hsv_to_rgb_converter_top
    import hsvrgb_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    hsvrgb_in_if.sink   i_hsv,
    hsvrgb_out_if.source o_rgb
);

    logic               front_valid, front_ready;
    t_front_beat        front_beat;
    logic               scale_valid, scale_ready;
    t_scale_beat        scale_beat;

    logic               r_o_valid;
    logic [FIELD_W-1:0] r_o_red, r_o_green, r_o_blue;
    logic [FIELD_W-1:0] n_red, n_green, n_blue;
    logic [FIELD_W-1:0] sel_r, sel_g, sel_b;
    logic               o_en;

    hsvrgb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hsv   (i_hsv),
        .o_valid (front_valid),
        .i_ready (front_ready),
        .o_beat  (front_beat)
    );

    hsvrgb_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_beat  (front_beat),
        .o_valid (scale_valid),
        .i_ready (scale_ready),
        .o_beat  (scale_beat)
    );

    assign o_en        = !r_o_valid || o_rgb.ready;
    assign scale_ready = o_en;

    always_comb begin
        sel_r = '0;
        sel_g = '0;
        sel_b = '0;
        unique case (scale_beat.sector)
            SEC_RED_YEL: begin sel_r = scale_beat.c; sel_g = scale_beat.x; end
            SEC_YEL_GRN: begin sel_r = scale_beat.x; sel_g = scale_beat.c; end
            SEC_GRN_CYN: begin sel_g = scale_beat.c; sel_b = scale_beat.x; end
            SEC_CYN_BLU: begin sel_g = scale_beat.x; sel_b = scale_beat.c; end
            SEC_BLU_MAG: begin sel_r = scale_beat.x; sel_b = scale_beat.c; end
            default:     begin sel_r = scale_beat.c; sel_b = scale_beat.x; end
        endcase
        n_red   = sel_r + scale_beat.m;
        n_green = sel_g + scale_beat.m;
        n_blue  = sel_b + scale_beat.m;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_en) begin
            r_o_valid <= scale_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en && scale_valid) begin
            r_o_red   <= n_red;
            r_o_green <= n_green;
            r_o_blue  <= n_blue;
        end
    end

    assign o_rgb.valid = r_o_valid;
    assign o_rgb.red   = r_o_red;
    assign o_rgb.green = r_o_green;
    assign o_rgb.blue  = r_o_blue;

endmodule

`default_nettype wire

@@ tb/sv/hsvrgb_color_checker.sv @@
// Checker for the HSV to RGB converter: predicts each RGB beat from the HSV beat
// taken at the input and compares it with the beat leaving the output.
// Depends on hsvrgb_pkg and the channel interfaces in hsvrgb_if.
module hsvrgb_color_checker
    import hsvrgb_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    hsvrgb_in_if  i_hsv,
    hsvrgb_out_if i_rgb,
    output int    o_fail_count,
    output int    o_pending_count
);

    typedef struct packed {
        logic [FIELD_W-1:0] red;
        logic [FIELD_W-1:0] green;
        logic [FIELD_W-1:0] blue;
    } t_rgb_color;

    t_rgb_color expected_colors[$];
    int         fail_total = 0;

    function automatic logic [FIELD_W-1:0] limit_to_one(logic [FIELD_W-1:0] raw);
        return (raw > ONE) ? ONE : raw;
    endfunction

    function automatic t_rgb_color predict_rgb(logic [HUE_W-1:0] hue,
                                               logic [FIELD_W-1:0] sat_raw,
                                               logic [FIELD_W-1:0] bri_raw);
        logic [FIELD_W-1:0] sat, bri, chroma, second, offset;
        int unsigned        reduced, pair_pos, mid_dev, weight;
        t_sector            sector;
        t_rgb_color         rgb;
        sat      = limit_to_one(sat_raw);
        bri      = limit_to_one(bri_raw);
        reduced  = 32'(hue) % 32'(HUE_FULL);
        sector   = t_sector'(reduced / 32'(HUE_SECTOR));
        pair_pos = reduced % 32'(HUE_PAIR);
        mid_dev  = (pair_pos >= 32'(HUE_SECTOR)) ? pair_pos - 32'(HUE_SECTOR)
                                                 : 32'(HUE_SECTOR) - pair_pos;
        weight   = 32'(HUE_SECTOR) - mid_dev;
        chroma   = FIELD_W'((32'(bri) * 32'(sat)) >> FRAC_BITS);
        second   = FIELD_W'((32'(chroma) * weight) / 32'(HUE_SECTOR));
        offset   = bri - chroma;
        rgb      = '0;
        case (sector)
            SEC_RED_YEL: begin
                rgb.red   = chroma;
                rgb.green = second;
            end
            SEC_YEL_GRN: begin
                rgb.red   = second;
                rgb.green = chroma;
            end
            SEC_GRN_CYN: begin
                rgb.green = chroma;
                rgb.blue  = second;
            end
            SEC_CYN_BLU: begin
                rgb.green = second;
                rgb.blue  = chroma;
            end
            SEC_BLU_MAG: begin
                rgb.red   = second;
                rgb.blue  = chroma;
            end
            default: begin
                rgb.red   = chroma;
                rgb.blue  = second;
            end
        endcase
        rgb.red   = rgb.red + offset;
        rgb.green = rgb.green + offset;
        rgb.blue  = rgb.blue + offset;
        return rgb;
    endfunction

    task automatic check_channel(string channel, logic [FIELD_W-1:0] want,
                                 logic [FIELD_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, channel, want, got);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_rgb_color want;
        if (!i_rst_n) begin
            expected_colors.delete();
        end else begin
            if (i_hsv.valid && i_hsv.ready) begin
                expected_colors.push_back(predict_rgb(i_hsv.hue, i_hsv.saturation,
                                                      i_hsv.brightness));
            end
            if (i_rgb.valid && i_rgb.ready) begin
                if (expected_colors.size() == 0) begin
                    $display("%0t: unexpected RGB beat: expected none, got %0d/%0d/%0d",
                             $time, i_rgb.red, i_rgb.green, i_rgb.blue);
                    fail_total++;
                end else begin
                    want = expected_colors.pop_front();
                    check_channel("red", want.red, i_rgb.red);
                    check_channel("green", want.green, i_rgb.green);
                    check_channel("blue", want.blue, i_rgb.blue);
                end
            end
        end
        o_pending_count <= expected_colors.size();
        o_fail_count    <= fail_total;
    end

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench top for hsv_to_rgb_converter_top: clock, reset, HSV stimulus and
// RGB backpressure; the checker in hsvrgb_color_checker does all comparison.
// Depends on hsvrgb_pkg, hsvrgb_if and the converter RTL.
module tb_top;
    import hsvrgb_pkg::*;

    localparam int RANDOM_COLORS     = 800;
    localparam int LONG_STALL_CYCLES = 300;
    localparam int SEND_IDLE[3]      = '{27, 77, 0};
    localparam int RECV_IDLE[3]      = '{77, 27, 0};

    logic clk;
    logic rst_n;
    logic hsv_taken = 1'b0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    bit   long_stall_req = 1'b0;
    int   fail_count;
    int   pending_count;

    hsvrgb_in_if  hsv_ch ();
    hsvrgb_out_if rgb_ch ();

    hsv_to_rgb_converter_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_hsv   (hsv_ch),
        .o_rgb   (rgb_ch)
    );

    hsvrgb_color_checker color_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_hsv           (hsv_ch),
        .i_rgb           (rgb_ch),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        hsv_taken <= hsv_ch.valid && hsv_ch.ready;
    end

    initial begin : run_limit
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // output backpressure; one long hold-off on request so the pipe fills up
    initial begin : rgb_receiver
        rgb_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (long_stall_req) begin
                rgb_ch.ready = 1'b0;
                repeat (LONG_STALL_CYCLES) @(negedge clk);
                long_stall_req = 1'b0;
            end else begin
                rgb_ch.ready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_color(logic [HUE_W-1:0] hue, logic [FIELD_W-1:0] sat,
                              logic [FIELD_W-1:0] bri);
        while ($urandom_range(99) < send_idle_pct) begin
            // junk on the payload while valid is low
            hsv_ch.valid      = 1'b0;
            hsv_ch.hue        = HUE_W'($urandom);
            hsv_ch.saturation = FIELD_W'($urandom);
            hsv_ch.brightness = FIELD_W'($urandom);
            @(negedge clk);
        end
        hsv_ch.valid      = 1'b1;
        hsv_ch.hue        = hue;
        hsv_ch.saturation = sat;
        hsv_ch.brightness = bri;
        do @(negedge clk); while (!hsv_taken);
    endtask

    // mostly in 0..1.0, sometimes the whole field so values above one show up
    function automatic logic [FIELD_W-1:0] random_fraction();
        if ($urandom_range(7) == 0) return FIELD_W'($urandom);
        return FIELD_W'($urandom_range(ONE));
    endfunction

    initial begin : stimulus
        hsv_ch.valid      = 1'b0;
        hsv_ch.hue        = '0;
        hsv_ch.saturation = '0;
        hsv_ch.brightness = '0;
        rst_n             = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // sector edges, wrap of the hue, gray and saturating S/V
        send_color(16'd0,     ONE, ONE);
        send_color(16'd1920,  ONE, ONE);
        send_color(16'd3839,  ONE, ONE);
        send_color(16'd3840,  ONE, ONE);
        send_color(16'd7679,  ONE, ONE);
        send_color(16'd7680,  ONE, ONE);
        send_color(16'd11520, ONE, ONE);
        send_color(16'd15360, ONE, ONE);
        send_color(16'd19200, ONE, ONE);
        send_color(16'd23039, ONE, ONE);
        send_color(16'd23040, ONE, ONE);
        send_color(16'd46080, ONE, ONE);
        send_color(16'hFFFF,  ONE, ONE);
        send_color(16'd5000,  '0,  ONE);
        send_color(16'd12345, '0,  '0);
        send_color(16'd9000,  ONE, '0);
        send_color(16'd100,   ONE + FIELD_W'(1), ONE);
        send_color(16'd100,   ONE, ONE + FIELD_W'(1));
        send_color(16'd5000,  {FIELD_W{1'b1}}, {FIELD_W{1'b1}});
        send_color(16'd30000, 13'd2048, 13'd3000);
        send_color(16'd17000, 13'd1, 13'd4095);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = SEND_IDLE[phase];
            recv_idle_pct = RECV_IDLE[phase];
            if (phase == 2) long_stall_req = 1'b1;
            repeat (RANDOM_COLORS / 3) begin
                send_color(HUE_W'($urandom_range(65535)), random_fraction(),
                           random_fraction());
            end
        end
        hsv_ch.valid = 1'b0;

        while (pending_count != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/hsvrgb_pkg.sv
rtl/hsvrgb_if.sv
rtl/hsvrgb_front.sv
rtl/hsvrgb_scale.sv
rtl/hsv_to_rgb_converter_top.sv
tb/sv/hsvrgb_color_checker.sv
tb/sv/tb_top.sv
